[hdl/sit_pkg.sv]
// Package for the segment intersection test: widths, pipeline structs.
// Used by every module in hdl/.
package sit_pkg;
  localparam int COORD_BITS = 16;
  localparam int PARAM_FRAC_BITS = 14;
  localparam int PARAM_BITS = PARAM_FRAC_BITS + 2;
  localparam int TOL_BITS = 15;
  localparam logic [TOL_BITS-1:0] TOL_RESET = 15'd1638;
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W = CROSS_W;
  localparam int REM_W = MAG_W + PARAM_FRAC_BITS;
  // quotient bits kept; any larger magnitude fails the window anyway
  localparam int QUO_BITS = PARAM_FRAC_BITS + 3;
  localparam int IDX_W = $clog2(QUO_BITS + 1);
  localparam int CMP_W = MAG_W + QUO_BITS + 1;
  localparam int NCELLS = QUO_BITS + 1;

  typedef struct packed {
    logic [REM_W-1:0]    rem;
    logic [QUO_BITS-1:0] quo;
    logic                neg;
    logic                big;
  } sit_lane_t;

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic [MAG_W-1:0] den;
    sit_lane_t        ls;
    sit_lane_t        lt;
  } sit_cell_t;
endpackage

[hdl/sit_front.sv]
// Front end: differences, products, cross terms, magnitudes and signs.
// Depends on sit_pkg; feeds the first divider cell.
module sit_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [8*sit_pkg::COORD_BITS-1:0]  in_data,
  output sit_pkg::sit_cell_t                cell_out
);
  import sit_pkg::*;

  logic signed [COORD_BITS-1:0] p [8];
  logic a_valid, b_valid, c_valid;
  logic signed [DIFF_W-1:0] s1x, s1y, s2x, s2y, dx, dy;
  logic signed [PROD_W-1:0] m_den0, m_den1, m_s0, m_s1, m_t0, m_t1;
  logic signed [CROSS_W-1:0] c_den, c_s, c_t;
  logic signed [CROSS_W-1:0] c_den_next, c_s_next, c_t_next;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      p[k] = in_data[k*COORD_BITS +: COORD_BITS];
    end
    c_den_next = CROSS_W'(m_den0) - CROSS_W'(m_den1);
    c_s_next = CROSS_W'(m_s0) - CROSS_W'(m_s1);
    c_t_next = CROSS_W'(m_t0) - CROSS_W'(m_t1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      cell_out.valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
      b_valid <= a_valid;
      c_valid <= b_valid;
      cell_out.valid <= c_valid;
    end
    if (en) begin
      s1x <= DIFF_W'(p[2]) - DIFF_W'(p[0]);
      s1y <= DIFF_W'(p[3]) - DIFF_W'(p[1]);
      s2x <= DIFF_W'(p[6]) - DIFF_W'(p[4]);
      s2y <= DIFF_W'(p[7]) - DIFF_W'(p[5]);
      dx  <= DIFF_W'(p[0]) - DIFF_W'(p[4]);
      dy  <= DIFF_W'(p[1]) - DIFF_W'(p[5]);
      m_den0 <= s1x * s2y;
      m_den1 <= s2x * s1y;
      m_s0 <= s1x * dy;
      m_s1 <= s1y * dx;
      m_t0 <= s2x * dy;
      m_t1 <= s2y * dx;
      c_den <= c_den_next;
      c_s <= c_s_next;
      c_t <= c_t_next;
      cell_out.zero <= (c_den == '0);
      cell_out.den <= c_den[CROSS_W-1] ? MAG_W'(-c_den) : MAG_W'(c_den);
      cell_out.ls.rem <= {(c_s[CROSS_W-1] ? MAG_W'(-c_s) : MAG_W'(c_s)),
                          {PARAM_FRAC_BITS{1'b0}}};
      cell_out.lt.rem <= {(c_t[CROSS_W-1] ? MAG_W'(-c_t) : MAG_W'(c_t)),
                          {PARAM_FRAC_BITS{1'b0}}};
      cell_out.ls.neg <= c_s[CROSS_W-1] ^ c_den[CROSS_W-1];
      cell_out.lt.neg <= c_t[CROSS_W-1] ^ c_den[CROSS_W-1];
      cell_out.ls.quo <= '0;
      cell_out.lt.quo <= '0;
      cell_out.ls.big <= 1'b0;
      cell_out.lt.big <= 1'b0;
    end
  end
endmodule

[hdl/sit_div_cell.sv]
// One restoring-division cell: settles one quotient bit for both lanes.
// Depends on sit_pkg; chained from the top quotient bit down by the top level.
module sit_div_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic [sit_pkg::IDX_W-1:0]     idx,
  input  sit_pkg::sit_cell_t            cell_in,
  output sit_pkg::sit_cell_t            cell_out
);
  import sit_pkg::*;

  logic [CMP_W-1:0] dshift;
  sit_lane_t ls_next, lt_next;

  function automatic sit_lane_t step(sit_lane_t l, logic [CMP_W-1:0] d,
                                     logic [IDX_W-1:0] i);
    sit_lane_t r;
    r = l;
    if (CMP_W'(l.rem) >= d) begin
      r.rem = REM_W'(CMP_W'(l.rem) - d);
      // the top cell only flags a quotient too large for the window
      if (i == IDX_W'(QUO_BITS)) r.big = 1'b1;
      else r.quo[i] = 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    dshift = CMP_W'(cell_in.den) << idx;
    ls_next = step(cell_in.ls, dshift, idx);
    lt_next = step(cell_in.lt, dshift, idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (en) begin
      cell_out.valid <= cell_in.valid;
    end
    if (en) begin
      cell_out.zero <= cell_in.zero;
      cell_out.den <= cell_in.den;
      cell_out.ls <= ls_next;
      cell_out.lt <= lt_next;
    end
  end
endmodule

[hdl/sit_window.sv]
// Window test on the two quotients and clamp of the crossing parameter.
// Depends on sit_pkg; takes the last divider cell's output.
module sit_window (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic [sit_pkg::TOL_BITS-1:0]    tolerance,
  input  sit_pkg::sit_cell_t              cell_in,
  output logic                            res_valid,
  output logic                            res_hit,
  output logic [sit_pkg::PARAM_BITS-1:0]  res_param
);
  import sit_pkg::*;

  localparam int W = QUO_BITS + 2;
  logic signed [W-1:0] qs, qt, lo_b, hi_b, pmax, pmin;
  logic hit_next;
  logic [PARAM_BITS-1:0] param_next;

  always_comb begin
    qs = cell_in.ls.neg ? -W'(cell_in.ls.quo) : W'(cell_in.ls.quo);
    qt = cell_in.lt.neg ? -W'(cell_in.lt.quo) : W'(cell_in.lt.quo);
    lo_b = -W'(tolerance);
    hi_b = W'(1 << PARAM_FRAC_BITS) + W'(tolerance);
    pmax = W'((1 << (PARAM_BITS - 1)) - 1);
    pmin = -pmax - W'(1);
    hit_next = !cell_in.zero && !cell_in.ls.big && !cell_in.lt.big &&
               qs >= lo_b && qs <= hi_b && qt >= lo_b && qt <= hi_b;
    priority if (!hit_next) param_next = '0;
    else if (qt > pmax) param_next = PARAM_BITS'(pmax);
    else if (qt < pmin) param_next = PARAM_BITS'(pmin);
    else param_next = PARAM_BITS'(qt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= cell_in.valid;
    end
    if (en) begin
      res_hit <= hit_next;
      res_param <= param_next;
    end
  end
endmodule

[hdl/segment_intersection_test.sv]
// Segment intersection test: 4-stage front end, a chain of 18 divider
// cells, a window stage and an output register with skid slot.
// One pair per cycle while no result waits in the skid slot.
// The divider chain sets the depth; the skid slot lets the pipe stall
// as one while a result waits. Reset clears all valid bits and sets
// tolerance to 1638; no clearing pass.
module segment_intersection_test (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [14:0]   cfg_data,
  input  logic          s_tvalid,
  output logic          s_tready,
  // first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y
  input  logic [127:0]  s_tdata,
  output logic          m_tvalid,
  input  logic          m_tready,
  // hit [0], crossing_param [16:1], zero pad [23:17]
  output logic [23:0]   m_tdata
);
  import sit_pkg::*;

  logic [TOL_BITS-1:0] tolerance;
  logic en;
  logic skid_full;
  sit_cell_t chain [NCELLS+1];
  logic res_valid, res_hit;
  logic [PARAM_BITS-1:0] res_param;
  logic out_valid, out_hit, skid_hit;
  logic [PARAM_BITS-1:0] out_param, skid_param;
  logic out_load;

  assign cfg_ready = 1'b1;
  assign en = !skid_full;
  assign s_tready = en;
  assign out_load = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) tolerance <= TOL_RESET;
    else if (cfg_valid) tolerance <= cfg_data;
  end

  sit_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid), .in_data(s_tdata), .cell_out(chain[0])
  );

  for (genvar g = 0; g < NCELLS; g++) begin : g_cell
    sit_div_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .idx(IDX_W'(QUO_BITS - g)),
      .cell_in(chain[g]), .cell_out(chain[g+1])
    );
  end

  sit_window u_window (
    .clk(clk), .rst(rst), .en(en), .tolerance(tolerance),
    .cell_in(chain[NCELLS]),
    .res_valid(res_valid), .res_hit(res_hit), .res_param(res_param)
  );

  // result from the pipe goes to the output register, or parks in skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (out_load) begin
      if (skid_full) begin
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid && en) begin
      skid_full <= 1'b1;
    end
    if (out_load) begin
      out_hit <= skid_full ? skid_hit : res_hit;
      out_param <= skid_full ? skid_param : res_param;
    end else if (res_valid && en) begin
      skid_hit <= res_hit;
      skid_param <= res_param;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata = {7'd0, out_param, out_hit};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid) else $error("skid holds data with empty output");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_hit) |-> (out_param == '0))
    else $error("crossing parameter nonzero without hit");
  a_hit_lower: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_hit) |-> ($signed({out_param[PARAM_BITS-1], out_param})
      >= -$signed({2'b00, tolerance})))
    else $error("hit below tolerance window");
endmodule

[verif/segment_intersection_test_test.sv]
// Testbench for segment_intersection_test: random and directed segment pairs
// checked against a scoreboard predictor. Depends on sit_pkg and the block RTL.
`timescale 1ns / 100ps

module segment_intersection_test_test;
  import sit_pkg::*;

  localparam int ONE_Q = 1 << PARAM_FRAC_BITS;
  localparam int DRAIN_CYCLES = 40;
  localparam int IDLE_LIMIT = 3000;

  typedef struct {
    bit               hit;
    logic [PARAM_BITS-1:0] param;
  } crossing_t;

  class crossing_board;
    crossing_t pending[$];
    longint    tol;
    int        errors;

    function new();
      tol = TOL_RESET;
      errors = 0;
    endfunction

    // trunc(num * 2^frac / den) with the magnitude capped at 2^62
    function longint fixed_quot(longint num, longint den);
      longint n, v, q;
      n = (num < 0) ? -num : num;
      v = (den < 0) ? -den : den;
      q = (n << PARAM_FRAC_BITS) / v;
      if (q > (longint'(1) << 62)) q = longint'(1) << 62;
      return ((num < 0) != (den < 0)) ? -q : q;
    endfunction

    function void note_pair(logic [127:0] d);
      longint c[8];
      longint s1x, s1y, s2x, s2y, dx, dy, den, s, t, lo_b, hi_b;
      crossing_t r;
      for (int i = 0; i < 8; i++) c[i] = longint'($signed(d[16*i +: 16]));
      s1x = c[2] - c[0];
      s1y = c[3] - c[1];
      s2x = c[6] - c[4];
      s2y = c[7] - c[5];
      dx = c[0] - c[4];
      dy = c[1] - c[5];
      den = s1x * s2y - s2x * s1y;
      r.hit = 0;
      r.param = '0;
      if (den != 0) begin
        s = fixed_quot(s1x * dy - s1y * dx, den);
        t = fixed_quot(s2x * dy - s2y * dx, den);
        lo_b = -tol;
        hi_b = ONE_Q + tol;
        if (s >= lo_b && s <= hi_b && t >= lo_b && t <= hi_b) begin
          if (t > 32767) t = 32767;
          if (t < -32768) t = -32768;
          r.hit = 1;
          r.param = t[PARAM_BITS-1:0];
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic [23:0] d);
      crossing_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[0] !== e.hit) begin
        $display("%0t: hit expected %0d actual %0d", $realtime, e.hit, d[0]);
        errors++;
      end
      if (d[16:1] !== e.param) begin
        $display("%0t: crossing_param expected %h actual %h", $realtime, e.param, d[16:1]);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [14:0] cfg_data;
  logic s_tvalid, s_tready;
  logic [127:0] s_tdata;
  logic m_tvalid, m_tready;
  logic [23:0] m_tdata;

  crossing_board board;
  int burst_left;
  bit long_stall_req;
  int idle_cycles;

  segment_intersection_test dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial board = new();

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) board.note_pair(s_tdata);
    if (!rst && m_tvalid && m_tready) board.check_result(m_tdata);
  end

  // receiver: pattern changes every so often, plus one long hold-off on request
  int hold_left, mode, mode_left;
  bit stall_done;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
      hold_left <= 0;
      mode <= 0;
      mode_left <= 0;
      stall_done <= 0;
    end else if (long_stall_req && !stall_done) begin
      stall_done <= 1;
      hold_left <= 300;
      m_tready <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 0;
    end else begin
      if (mode_left == 0) begin
        mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 150);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (mode)
        0: m_tready <= 1;
        1: m_tready <= $urandom_range(0, 1);
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_pair(logic [127:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        s_tvalid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tvalid <= 1;
    s_tdata <= d;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain_results();
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [14:0] v);
    s_tvalid <= 0;
    burst_left = 0;
    drain_results();
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    board.tol = v;
  endtask

  function automatic int rand_coord(int kind);
    case (kind)
      0: return $signed(16'($urandom));
      1: return $urandom_range(0, 1) ? 32767 : -32768;
      default: return int'($urandom_range(0, 4000)) - 2000;
    endcase
  endfunction

  task automatic send_random(int count);
    int kind, v[8];
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 9);
      for (int i = 0; i < 8; i++)
        v[i] = rand_coord(kind < 3 ? 0 : (kind == 3 ? ($urandom_range(0, 1) ? 1 : 2) : 2));
      // make some pairs parallel by reusing the first direction
      if (kind == 9) begin
        v[6] = v[4] + (v[2] - v[0]);
        v[7] = v[5] + (v[3] - v[1]);
      end
      send_pair({v[6][15:0], v[7][15:0], v[4][15:0], v[5][15:0],
                 v[2][15:0], v[3][15:0], v[0][15:0], v[1][15:0]});
    end
  endtask

  // fields go x then y, lowest first: repack as x0 at [15:0], y0 at [31:16], ...
  function automatic logic [127:0] seg(int x0, int y0, int x1, int y1,
                                       int x2, int y2, int x3, int y3);
    return {y3[15:0], x3[15:0], y2[15:0], x2[15:0], y1[15:0], x1[15:0], y0[15:0], x0[15:0]};
  endfunction

  initial begin
    rst = 1;
    cfg_valid = 0;
    cfg_data = '0;
    s_tvalid = 0;
    s_tdata = '0;
    long_stall_req = 0;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed pairs at reset tolerance
    send_pair(seg(-256, 0, 256, 0, 0, -256, 0, 256));
    send_pair(seg(0, 0, 256, 0, 0, 256, 256, 256));
    send_pair(seg(0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(seg(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(seg(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_pair(seg(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_pair(seg(0, 0, 256, 0, 0, 0, 0, 256));
    send_pair(seg(0, 0, 256, 0, 256, 0, 256, 256));
    send_pair(seg(0, 0, 256, 0, 300, -256, 300, 256));
    send_pair(seg(0, 0, 256, 0, 280, -256, 280, 256));
    send_pair(seg(0, 0, 256, 0, -20, -256, -20, 256));
    send_pair(seg(0, 0, 32767, 1, 0, -32768, 32766, -32767));
    send_pair(seg(0, 0, 32767, 1, 0, 32767, 32766, -32768));
    send_pair(seg(-32768, 0, 32767, 0, 0, -32768, 0, 32767));

    // random part; fill the pipe once while the output is held off
    long_stall_req <= 1;
    send_random(400);

    write_tolerance(15'd0);
    send_pair(seg(0, 0, 256, 0, 0, 0, 0, 256));
    send_pair(seg(0, 0, 256, 0, 256, -256, 256, 256));
    send_random(350);

    write_tolerance(15'(ONE_Q));
    // first pair: both parameters at 2.0, crossing_param saturates; second pair: parameters 2.0 and -1.0
    send_pair(seg(0, 0, 128, 0, 256, -256, 256, -128));
    send_pair(seg(0, 0, 128, 0, -128, -256, -128, -128));
    send_random(400);

    write_tolerance(15'h7fff);
    send_random(200);

    write_tolerance(15'($urandom_range(0, ONE_Q)));
    send_random(200);

    s_tvalid <= 0;
    drain_results();
    if (board.errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
